// File: hw/rtl/fppid_pkg.sv
package fppid_pkg;

  localparam int DefaultChannels = 2;
  localparam int DataW           = 16;
  localparam int CfgIdxW         = 3;
  localparam int FracBits        = 14;
  localparam int AccW            = 32;
  localparam int CtlW            = AccW - FracBits;

  localparam logic [DataW-1:0] KpReset     = 16'd500;
  localparam logic [DataW-1:0] KiReset     = 16'd200;
  localparam logic [DataW-1:0] KdReset     = 16'd200;
  localparam logic [DataW-1:0] TargetReset = 16'd3000;
  localparam logic [DataW-1:0] LowerReset  = 16'd0;
  localparam logic [DataW-1:0] UpperReset  = 16'h1000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKpGain      = 3'd0,
    CfgKiGain      = 3'd1,
    CfgKdGain      = 3'd2,
    CfgTargetValue = 3'd3,
    CfgLowerLimit  = 3'd4,
    CfgUpperLimit  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] kp_gain;
    logic [DataW-1:0] ki_gain;
    logic [DataW-1:0] kd_gain;
    logic [DataW-1:0] target_value;
    logic [DataW-1:0] lower_limit;
    logic [DataW-1:0] upper_limit;
  } cfg_t;

endpackage

// File: hw/rtl/fppid_cfg.sv
module fppid_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [fppid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fppid_pkg::DataW-1:0]    cfg_data_i,
  output fppid_pkg::cfg_t                cfg_o
);
  import fppid_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgKpGain:      cfg_d.kp_gain      = cfg_data_i;
        CfgKiGain:      cfg_d.ki_gain      = cfg_data_i;
        CfgKdGain:      cfg_d.kd_gain      = cfg_data_i;
        CfgTargetValue: cfg_d.target_value = cfg_data_i;
        CfgLowerLimit:  cfg_d.lower_limit  = cfg_data_i;
        CfgUpperLimit:  cfg_d.upper_limit  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain      <= KpReset;
      cfg_q.ki_gain      <= KiReset;
      cfg_q.kd_gain      <= KdReset;
      cfg_q.target_value <= TargetReset;
      cfg_q.lower_limit  <= LowerReset;
      cfg_q.upper_limit  <= UpperReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/fppid_calc.sv
module fppid_calc (
  input  fppid_pkg::cfg_t               cfg_i,
  input  logic [fppid_pkg::DataW-1:0]   measurement_i,
  input  logic [fppid_pkg::AccW-1:0]    integral_i,
  input  logic [fppid_pkg::DataW-1:0]   drive_now_i,
  input  logic [fppid_pkg::DataW-1:0]   drive_prev_i,
  output logic [fppid_pkg::AccW-1:0]    integral_o,
  output logic [fppid_pkg::DataW-1:0]   drive_o
);
  import fppid_pkg::*;

  logic signed [DataW:0]       err;
  logic signed [DataW:0]       diff;
  logic signed [2*DataW+1:0]   p_full;
  logic signed [2*DataW+1:0]   i_full;
  logic signed [2*DataW+1:0]   d_full;
  logic signed [AccW-1:0]      i_inc;
  logic [AccW-1:0]             sum;
  logic signed [CtlW-1:0]      ctl;
  logic signed [CtlW-1:0]      lo;
  logic signed [CtlW-1:0]      hi;
  logic signed [CtlW-1:0]      clamped;

  assign err  = $signed({1'b0, measurement_i}) - $signed({1'b0, cfg_i.target_value});
  assign diff = $signed({1'b0, drive_now_i}) - $signed({1'b0, drive_prev_i});

  assign p_full = $signed({1'b0, cfg_i.kp_gain}) * err;
  assign i_full = $signed({1'b0, cfg_i.ki_gain}) * err;
  assign d_full = $signed({1'b0, cfg_i.kd_gain}) * diff;

  assign i_inc      = $signed(i_full[AccW-1:0]) >>> FracBits;
  assign integral_o = integral_i + AccW'(i_inc);
  assign sum        = p_full[AccW-1:0] + integral_o + d_full[AccW-1:0];
  assign ctl        = $signed(sum[AccW-1:FracBits]);

  assign lo = $signed({{(CtlW-DataW){1'b0}}, cfg_i.lower_limit});
  assign hi = $signed({{(CtlW-DataW){1'b0}}, cfg_i.upper_limit});

  always_comb begin
    clamped = ctl;
    if (clamped < lo) begin
      clamped = lo;
    end
    if (clamped > hi) begin
      clamped = hi;
    end
  end

  assign drive_o = cfg_i.upper_limit - clamped[DataW-1:0];

endmodule

// File: hw/rtl/fixed_point_pid_multichannel_unit.sv
// An input transfer is captured in the input register, and its result is then registered in the result register.
// One item per cycle while out_ready_i does not stall the output, also on the same channel back to back.
// The input register feeds the controller math, which updates the channel state
// and loads the result register at the same edge.
// Reset loads the default gains and limits and clears all channel state.
module fixed_point_pid_multichannel_unit #(
  parameter int CHANNELS = fppid_pkg::DefaultChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fppid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fppid_pkg::DataW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           channel_i,
  input  logic [fppid_pkg::DataW-1:0]    measurement_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           channel_out_o,
  output logic [fppid_pkg::DataW-1:0]    drive_o
);
  import fppid_pkg::*;

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t cfg;

  logic             in_valid_q;
  logic             in_ch_q;
  logic [DataW-1:0] in_meas_q;

  logic             out_valid_q;
  logic             out_ch_q;
  logic [DataW-1:0] out_drive_q;

  logic [AccW-1:0]  integ_q      [CHANNELS];
  logic [DataW-1:0] drive_now_q  [CHANNELS];
  logic [DataW-1:0] drive_prev_q [CHANNELS];

  logic              advance;
  logic              ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  logic [AccW-1:0]   integ_rd;
  logic [DataW-1:0]  dnow_rd;
  logic [DataW-1:0]  dprev_rd;
  logic [AccW-1:0]   integ_d;
  logic [DataW-1:0]  drive_d;

  fppid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign ch_ok    = (int'(in_ch_q) < CHANNELS);
  assign ch_idx   = ChIdxW'(in_ch_q);
  assign integ_rd = ch_ok ? integ_q[ch_idx] : '0;
  assign dnow_rd  = ch_ok ? drive_now_q[ch_idx] : '0;
  assign dprev_rd = ch_ok ? drive_prev_q[ch_idx] : '0;

  fppid_calc u_calc (
    .cfg_i         (cfg),
    .measurement_i (in_meas_q),
    .integral_i    (integ_rd),
    .drive_now_i   (dnow_rd),
    .drive_prev_i  (dprev_rd),
    .integral_o    (integ_d),
    .drive_o       (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_ch_q   <= channel_i;
      in_meas_q <= measurement_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ch_q    <= in_ch_q;
      out_drive_q <= ch_ok ? drive_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ_q[i]      <= '0;
        drive_now_q[i]  <= '0;
        drive_prev_q[i] <= '0;
      end
    end else if (advance && ch_ok) begin
      integ_q[ch_idx]      <= integ_d;
      drive_now_q[ch_idx]  <= drive_d;
      drive_prev_q[ch_idx] <= dnow_rd;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign drive_o       = out_drive_q;

endmodule
